>>> rtl/hrp_pkg.sv
// Shared types, character codes and byte classifier for the HTTP request parser.
package hrp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_QUEST = 8'h3F;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_C  = 8'h43;
  localparam logic [7:0] CHR_UP_D  = 8'h44;
  localparam logic [7:0] CHR_UP_G  = 8'h47;
  localparam logic [7:0] CHR_UP_H  = 8'h48;
  localparam logic [7:0] CHR_UP_O  = 8'h4F;
  localparam logic [7:0] CHR_UP_P  = 8'h50;
  localparam logic [7:0] CHR_UP_T  = 8'h54;
  localparam logic [7:0] CHR_UP_U  = 8'h55;
  localparam logic [7:0] CHR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHR_LO_A  = 8'h61;
  localparam logic [7:0] CHR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHR_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_REJECT   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    METH_NONE    = 4'd0,
    METH_GET     = 4'd1,
    METH_HEAD    = 4'd2,
    METH_POST    = 4'd3,
    METH_PUT     = 4'd4,
    METH_PATCH   = 4'd5,
    METH_DELETE  = 4'd6,
    METH_CONNECT = 4'd7,
    METH_OPTIONS = 4'd8,
    METH_TRACE   = 4'd9
  } method_e;

  typedef enum logic [2:0] {
    VER_UNKNOWN = 3'd0,
    VER_0_9     = 3'd1,
    VER_1_0     = 3'd2,
    VER_1_1     = 3'd3,
    VER_2_0     = 3'd4
  } version_e;

  typedef enum logic [3:0] {
    FK_NONE   = 4'd0,
    FK_SCHEME = 4'd1,
    FK_HOST   = 4'd2,
    FK_PORT   = 4'd3,
    FK_PATH   = 4'd4,
    FK_QUERY  = 4'd5,
    FK_FRAG   = 4'd6,
    FK_HNAME  = 4'd7,
    FK_HVALUE = 4'd8
  } kind_e;

  typedef enum logic [4:0] {
    PH_START      = 5'd0,
    PH_START_LF   = 5'd1,
    PH_METHOD     = 5'd2,
    PH_URI        = 5'd3,
    PH_H          = 5'd4,
    PH_HT         = 5'd5,
    PH_HTT        = 5'd6,
    PH_HTTP       = 5'd7,
    PH_SLASH      = 5'd8,
    PH_MAJOR      = 5'd9,
    PH_DOT        = 5'd10,
    PH_MINOR      = 5'd11,
    PH_LINE_CR    = 5'd12,
    PH_LINE_LF    = 5'd13,
    PH_NAME_START = 5'd14,
    PH_NAME       = 5'd15,
    PH_VALUE      = 5'd16,
    PH_HDR_LF     = 5'd17,
    PH_LWS        = 5'd18,
    PH_END        = 5'd19
  } phase_e;

  typedef enum logic [3:0] {
    UP_START  = 4'd0,
    UP_SCHEME = 4'd1,
    UP_COLON  = 4'd2,
    UP_SLASH2 = 4'd3,
    UP_HOST   = 4'd4,
    UP_PORT   = 4'd5,
    UP_PATH   = 4'd6,
    UP_QUERY  = 4'd7,
    UP_FRAG   = 4'd8
  } uri_e;

  typedef struct packed {
    logic    token;
    logic    uri;
    logic    ctl;
    logic    blank;
    logic    alpha;
    logic    digit;
    logic    start_ok;
    method_e start_method;
  } class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    class_t     cls;
  } word_t;

  function automatic logic tok_char(logic [7:0] c);
    logic res;
    res = 1'b0;
    if (c >= 8'h21 && c <= 8'h7E) begin
      res = !(c inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
                        8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B,
                        8'h7D});
    end
    return res;
  endfunction

  function automatic class_t classify(logic [7:0] c);
    class_t r;
    r.token        = tok_char(c);
    r.uri          = (c >= 8'h21 && c <= 8'h7E);
    r.ctl          = (c < CHR_SPACE) || (c == CHR_DEL);
    r.blank        = (c == CHR_SPACE) || (c == CHR_TAB);
    r.alpha        = (c >= CHR_UP_A && c <= CHR_UP_Z) || (c >= CHR_LO_A && c <= CHR_LO_Z);
    r.digit        = (c >= CHR_ZERO && c <= CHR_NINE);
    r.start_ok     = 1'b1;
    r.start_method = METH_NONE;
    case (c)
      CHR_UP_G: r.start_method = METH_GET;
      CHR_UP_H: r.start_method = METH_HEAD;
      CHR_UP_P: r.start_method = METH_NONE;
      CHR_UP_D: r.start_method = METH_DELETE;
      CHR_UP_C: r.start_method = METH_CONNECT;
      CHR_UP_O: r.start_method = METH_OPTIONS;
      CHR_UP_T: r.start_method = METH_TRACE;
      default:  r.start_ok     = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/hrp_front.sv
// Front end: takes input words, classifies each byte and pushes it into the queue.
module hrp_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            restart_i,
  input  logic            q_full_i,
  output logic            push_o,
  output hrp_pkg::word_t  word_o
);
  import hrp_pkg::*;

  // The stall comes straight from the registered queue fill, never from valid.
  assign in_stall_o     = q_full_i;
  assign push_o         = in_valid_i && !q_full_i;
  assign word_o.data    = data_byte_i;
  assign word_o.restart = restart_i;
  assign word_o.cls     = classify(data_byte_i);

endmodule

>>> rtl/hrp_queue.sv
// Short queue of classified words between the front end and the parser back end.
module hrp_queue #(
  parameter int unsigned Depth = hrp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrp_pkg::word_t  word_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hrp_pkg::word_t  word_o
);
  import hrp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  word_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign word_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

>>> rtl/hrp_back.sv
// Back end: request-line, URI and header state machines with the result register.
module hrp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  hrp_pkg::word_t  word_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      parse_status_o,
  output logic [3:0]      method_code_o,
  output logic [2:0]      version_code_o,
  output logic [3:0]      field_kind_o,
  output logic [7:0]      field_byte_o,
  output logic            header_start_o
);
  import hrp_pkg::*;

  phase_e     phase_q, phase_d, phase_b, phase_n;
  uri_e       uri_q, uri_d, uri_b, uri_n;
  method_e    meth_q, meth_d, meth_b, meth_n;
  logic [3:0] major_q, major_d, major_b, major_n;
  version_e   ver_q, ver_d, ver_b, ver_n;

  status_e    st;
  kind_e      kind;
  logic       hstart;
  logic [7:0] c;
  logic [3:0] minor;
  class_t     cls;

  logic       out_valid_q;
  status_e    status_q;
  kind_e      kind_q;
  logic [7:0] fbyte_q;
  logic       hstart_q;

  assign c     = word_i.data;
  assign cls   = word_i.cls;
  assign minor = c[3:0];
  assign pop_o = valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    // Restart puts the machines back to request start before this byte is parsed.
    phase_b = word_i.restart ? PH_START    : phase_q;
    uri_b   = word_i.restart ? UP_START    : uri_q;
    meth_b  = word_i.restart ? METH_NONE   : meth_q;
    major_b = word_i.restart ? 4'd1        : major_q;
    ver_b   = word_i.restart ? VER_UNKNOWN : ver_q;
    phase_n = phase_b;
    uri_n   = uri_b;
    meth_n  = meth_b;
    major_n = major_b;
    ver_n   = ver_b;
    st      = ST_PROGRESS;
    kind    = FK_NONE;
    hstart  = 1'b0;

    case (phase_b)
      PH_START: begin
        if (c == CHR_CR) begin
          phase_n = PH_START_LF;
        end else if (!cls.token || !cls.start_ok) begin
          st = ST_REJECT;
        end else begin
          meth_n  = cls.start_method;
          phase_n = PH_METHOD;
        end
      end
      PH_START_LF: begin
        if (c == CHR_LF) phase_n = PH_START;
        else st = ST_REJECT;
      end
      PH_METHOD: begin
        if (cls.token) begin
          // Only a method that began with P is still open here.
          if (meth_b == METH_NONE) begin
            if (c == CHR_UP_O) meth_n = METH_POST;
            else if (c == CHR_UP_U) meth_n = METH_PUT;
            else if (c == CHR_UP_A) meth_n = METH_PATCH;
            else st = ST_REJECT;
          end
        end else if (c == CHR_SPACE && meth_b != METH_NONE) begin
          phase_n = PH_URI;
        end else begin
          st = ST_REJECT;
        end
      end
      PH_URI: begin
        if (cls.uri) begin
          case (uri_b)
            UP_START: begin
              if (c == CHR_SLASH) begin
                uri_n = UP_PATH;
                kind  = FK_PATH;
              end else if (cls.alpha) begin
                uri_n = UP_SCHEME;
                kind  = FK_SCHEME;
              end else begin
                st = ST_REJECT;
              end
            end
            UP_SCHEME: begin
              if (cls.alpha) kind = FK_SCHEME;
              else if (c == CHR_COLON) uri_n = UP_COLON;
              else st = ST_REJECT;
            end
            UP_COLON: begin
              if (c == CHR_SLASH) uri_n = UP_SLASH2;
              else st = ST_REJECT;
            end
            UP_SLASH2: begin
              if (c == CHR_SLASH) uri_n = UP_HOST;
              else st = ST_REJECT;
            end
            UP_HOST: begin
              if (c == CHR_SLASH) begin
                uri_n = UP_PATH;
                kind  = FK_PATH;
              end else if (c == CHR_COLON) begin
                uri_n = UP_PORT;
              end else begin
                kind = FK_HOST;
              end
            end
            UP_PORT: begin
              if (cls.digit) begin
                kind = FK_PORT;
              end else if (c == CHR_SLASH) begin
                uri_n = UP_PATH;
                kind  = FK_PATH;
              end else begin
                st = ST_REJECT;
              end
            end
            UP_PATH: begin
              if (c == CHR_QUEST) uri_n = UP_QUERY;
              else if (c == CHR_HASH) uri_n = UP_FRAG;
              else kind = FK_PATH;
            end
            UP_QUERY: begin
              if (c == CHR_HASH) uri_n = UP_FRAG;
              else kind = FK_QUERY;
            end
            UP_FRAG: kind = FK_FRAG;
            default: st = ST_REJECT;
          endcase
        end else if (c == CHR_SPACE) begin
          phase_n = PH_H;
        end else begin
          st = ST_REJECT;
        end
      end
      PH_H: begin
        if (c == CHR_UP_H) phase_n = PH_HT;
        else st = ST_REJECT;
      end
      PH_HT: begin
        if (c == CHR_UP_T) phase_n = PH_HTT;
        else st = ST_REJECT;
      end
      PH_HTT: begin
        if (c == CHR_UP_T) phase_n = PH_HTTP;
        else st = ST_REJECT;
      end
      PH_HTTP: begin
        if (c == CHR_UP_P) phase_n = PH_SLASH;
        else st = ST_REJECT;
      end
      PH_SLASH: begin
        if (c == CHR_SLASH) phase_n = PH_MAJOR;
        else st = ST_REJECT;
      end
      PH_MAJOR: begin
        if (cls.digit) begin
          major_n = c[3:0];
          phase_n = PH_DOT;
        end else begin
          st = ST_REJECT;
        end
      end
      PH_DOT: begin
        if (c == CHR_DOT) phase_n = PH_MINOR;
        else st = ST_REJECT;
      end
      PH_MINOR: begin
        if (cls.digit) begin
          // An unlisted version is accepted but leaves the held version alone.
          if (major_b == 4'd0 && minor == 4'd9) ver_n = VER_0_9;
          if (major_b == 4'd1 && minor == 4'd0) ver_n = VER_1_0;
          if (major_b == 4'd1 && minor == 4'd1) ver_n = VER_1_1;
          if (major_b == 4'd2 && minor == 4'd0) ver_n = VER_2_0;
          phase_n = PH_LINE_CR;
        end else begin
          st = ST_REJECT;
        end
      end
      PH_LINE_CR: begin
        if (c == CHR_CR) phase_n = PH_LINE_LF;
        else st = ST_REJECT;
      end
      PH_LINE_LF: begin
        if (c == CHR_LF) phase_n = PH_NAME_START;
        else st = ST_REJECT;
      end
      PH_NAME_START, PH_LWS: begin
        if (phase_b == PH_LWS && cls.blank) begin
          phase_n = PH_VALUE;
        end else if (c == CHR_CR) begin
          phase_n = PH_END;
        end else if (cls.token) begin
          kind    = FK_HNAME;
          hstart  = 1'b1;
          phase_n = PH_NAME;
        end else begin
          st = ST_REJECT;
        end
      end
      PH_NAME: begin
        if (cls.token) kind = FK_HNAME;
        else if (c == CHR_COLON) phase_n = PH_VALUE;
        else st = ST_REJECT;
      end
      PH_VALUE: begin
        if (cls.blank) begin
          st = ST_PROGRESS;
        end else if (c == CHR_CR) begin
          phase_n = PH_HDR_LF;
        end else if (!cls.ctl) begin
          kind = FK_HVALUE;
        end else begin
          st = ST_REJECT;
        end
      end
      PH_HDR_LF: begin
        if (c == CHR_LF) phase_n = PH_LWS;
        else st = ST_REJECT;
      end
      PH_END: begin
        if (c == CHR_LF) st = ST_ACCEPT;
        else st = ST_REJECT;
      end
      default: st = ST_REJECT;
    endcase

    if (st == ST_REJECT) begin
      kind   = FK_NONE;
      hstart = 1'b0;
    end

    phase_d = phase_q;
    uri_d   = uri_q;
    meth_d  = meth_q;
    major_d = major_q;
    ver_d   = ver_q;
    if (pop_o) begin
      phase_d = (st == ST_REJECT) ? phase_b : phase_n;
      uri_d   = (st == ST_REJECT) ? uri_b   : uri_n;
      meth_d  = (st == ST_REJECT) ? meth_b  : meth_n;
      major_d = (st == ST_REJECT) ? major_b : major_n;
      ver_d   = (st == ST_REJECT) ? ver_b   : ver_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      uri_q       <= UP_START;
      meth_q      <= METH_NONE;
      major_q     <= 4'd1;
      ver_q       <= VER_UNKNOWN;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      uri_q   <= uri_d;
      meth_q  <= meth_d;
      major_q <= major_d;
      ver_q   <= ver_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= st;
      kind_q   <= kind;
      fbyte_q  <= (kind != FK_NONE) ? c : 8'h00;
      hstart_q <= hstart;
    end
  end

  // Method and version show the held values after the step.
  assign out_valid_o    = out_valid_q;
  assign parse_status_o = status_q;
  assign method_code_o  = meth_q;
  assign version_code_o = ver_q;
  assign field_kind_o   = kind_q;
  assign field_byte_o   = fbyte_q;
  assign header_start_o = hstart_q;

  a_reject_no_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_REJECT) |-> (kind_q == FK_NONE && !hstart_q))
    else $error("rejected word carries a field byte");

  a_hstart_is_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hstart_q) |-> (kind_q == FK_HNAME))
    else $error("header start outside a header name");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && st == ST_REJECT && !word_i.restart) |=>
      ($stable(phase_q) && $stable(uri_q) && $stable(meth_q) && $stable(ver_q)))
    else $error("rejected byte changed parser state");

  a_accept_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && st == ST_ACCEPT) |-> (phase_b == PH_END && c == CHR_LF))
    else $error("request complete outside the final phase");

  a_pop_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !pop_o) |=> out_valid_q)
    else $error("stalled result word was dropped");

endmodule

>>> rtl/http_request_line_header_parser.sv
// An accepted word passes through the word queue and then the result register before it
// can be taken. Throughput: one byte per clock while the output is not stalled; the parser
// phase register loop in the back end sets it. The input stalls only when the word queue
// has filled up, which happens while the output is stalled.
// Reset is asynchronous and active low: the parser returns to request start, method and
// version clear, the major digit reads one, the queue empties and no result word is valid.
module http_request_line_header_parser #(
  parameter int unsigned QueueDepth = hrp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] parse_status_o,
  output logic [3:0] method_code_o,
  output logic [2:0] version_code_o,
  output logic [3:0] field_kind_o,
  output logic [7:0] field_byte_o,
  output logic       header_start_o
);
  import hrp_pkg::*;

  logic  q_full, push, pop, q_valid;
  word_t push_word, pop_word;

  hrp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .word_o      (push_word)
  );

  hrp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .word_o  (pop_word)
  );

  hrp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .word_i         (pop_word),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .parse_status_o (parse_status_o),
    .method_code_o  (method_code_o),
    .version_code_o (version_code_o),
    .field_kind_o   (field_kind_o),
    .field_byte_o   (field_byte_o),
    .header_start_o (header_start_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP request-line and header parser.
module testbench;
  import hrp_pkg::*;

  localparam int unsigned ITEM_COUNT = 2000;
  localparam int unsigned CALM_AFTER = 1700;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    status_e    status;
    method_e    meth;
    version_e   ver;
    kind_e      kind;
    logic [7:0] fbyte;
    logic       hstart;
  } parse_word_t;

  // Tracks the parser state and holds the words the block still owes us.
  class parse_tracker;
    phase_e      phase;
    uri_e        uri_ph;
    method_e     meth;
    logic [3:0]  major;
    version_e    ver;
    parse_word_t pending_words[$];
    int unsigned mismatches;
    int unsigned words_seen;

    function new();
      clear();
      mismatches = 0;
      words_seen = 0;
    endfunction

    function void clear();
      phase = PH_START;
      uri_ph = UP_START;
      meth = METH_NONE;
      major = 4'd1;
      ver = VER_UNKNOWN;
    endfunction

    function bit is_tchar(logic [7:0] c);
      if (c < 8'h21 || c > 8'h7E) return 1'b0;
      case (c)
        "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=", "{", "}":
          return 1'b0;
        default:
          return 1'b1;
      endcase
    endfunction

    function bit is_uri_char(logic [7:0] c);
      return c >= 8'h21 && c <= 8'h7E;
    endfunction

    function bit is_ctl(logic [7:0] c);
      return c < CHR_SPACE || c == CHR_DEL;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CHR_SPACE || c == CHR_TAB;
    endfunction

    function bit alpha_char(logic [7:0] c);
      return (c >= CHR_UP_A && c <= CHR_UP_Z) || (c >= CHR_LO_A && c <= CHR_LO_Z);
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= CHR_ZERO && c <= CHR_NINE;
    endfunction

    function bit uri_step(logic [7:0] c, inout uri_e up, output kind_e k);
      bit ok;
      ok = 1'b1;
      k = FK_NONE;
      case (up)
        UP_START: begin
          if (c == CHR_SLASH) begin
            up = UP_PATH;
            k = FK_PATH;
          end else if (alpha_char(c)) begin
            up = UP_SCHEME;
            k = FK_SCHEME;
          end else begin
            ok = 1'b0;
          end
        end
        UP_SCHEME: begin
          if (alpha_char(c)) k = FK_SCHEME;
          else if (c == CHR_COLON) up = UP_COLON;
          else ok = 1'b0;
        end
        UP_COLON: if (c == CHR_SLASH) up = UP_SLASH2; else ok = 1'b0;
        UP_SLASH2: if (c == CHR_SLASH) up = UP_HOST; else ok = 1'b0;
        UP_HOST: begin
          // The slash that closes the host is already the first path byte.
          if (c == CHR_SLASH) begin
            up = UP_PATH;
            k = FK_PATH;
          end else if (c == CHR_COLON) begin
            up = UP_PORT;
          end else begin
            k = FK_HOST;
          end
        end
        UP_PORT: begin
          if (digit_char(c)) begin
            k = FK_PORT;
          end else if (c == CHR_SLASH) begin
            up = UP_PATH;
            k = FK_PATH;
          end else begin
            ok = 1'b0;
          end
        end
        UP_PATH: begin
          if (c == CHR_QUEST) up = UP_QUERY;
          else if (c == CHR_HASH) up = UP_FRAG;
          else k = FK_PATH;
        end
        UP_QUERY: if (c == CHR_HASH) up = UP_FRAG; else k = FK_QUERY;
        UP_FRAG: k = FK_FRAG;
        default: ok = 1'b0;
      endcase
      return ok;
    endfunction

    // Works out the word for one accepted byte; a rejected byte changes no state beyond its restart.
    function void parse_byte(logic [7:0] c, logic restart);
      phase_e      ph;
      uri_e        up;
      method_e     m;
      logic [3:0]  maj;
      logic [3:0]  minor;
      version_e    v;
      status_e     st;
      kind_e       k;
      logic        hs;
      parse_word_t w;
      if (restart) clear();
      ph = phase;
      up = uri_ph;
      m = meth;
      maj = major;
      v = ver;
      st = ST_PROGRESS;
      k = FK_NONE;
      hs = 1'b0;
      case (phase)
        PH_START: begin
          ph = PH_METHOD;
          case (c)
            CHR_CR:   ph = PH_START_LF;
            CHR_UP_G: m = METH_GET;
            CHR_UP_H: m = METH_HEAD;
            CHR_UP_P: m = METH_NONE;
            CHR_UP_D: m = METH_DELETE;
            CHR_UP_C: m = METH_CONNECT;
            CHR_UP_O: m = METH_OPTIONS;
            CHR_UP_T: m = METH_TRACE;
            default:  st = ST_REJECT;
          endcase
        end
        PH_START_LF: if (c == CHR_LF) ph = PH_START; else st = ST_REJECT;
        PH_METHOD: begin
          if (is_tchar(c)) begin
            // Only a method opened by P is still open after its first letter.
            if (m == METH_NONE) begin
              case (c)
                CHR_UP_O: m = METH_POST;
                CHR_UP_U: m = METH_PUT;
                CHR_UP_A: m = METH_PATCH;
                default:  st = ST_REJECT;
              endcase
            end
          end else if (c == CHR_SPACE && m != METH_NONE) begin
            ph = PH_URI;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_URI: begin
          if (is_uri_char(c)) begin
            if (!uri_step(c, up, k)) st = ST_REJECT;
          end else if (c == CHR_SPACE) begin
            ph = PH_H;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_H:     if (c == CHR_UP_H) ph = PH_HT; else st = ST_REJECT;
        PH_HT:    if (c == CHR_UP_T) ph = PH_HTT; else st = ST_REJECT;
        PH_HTT:   if (c == CHR_UP_T) ph = PH_HTTP; else st = ST_REJECT;
        PH_HTTP:  if (c == CHR_UP_P) ph = PH_SLASH; else st = ST_REJECT;
        PH_SLASH: if (c == CHR_SLASH) ph = PH_MAJOR; else st = ST_REJECT;
        PH_MAJOR: begin
          if (digit_char(c)) begin
            maj = 4'(c - CHR_ZERO);
            ph = PH_DOT;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_DOT: if (c == CHR_DOT) ph = PH_MINOR; else st = ST_REJECT;
        PH_MINOR: begin
          if (digit_char(c)) begin
            // An unlisted version keeps whatever version was held before.
            minor = 4'(c - CHR_ZERO);
            if (maj == 4'd0 && minor == 4'd9) v = VER_0_9;
            if (maj == 4'd1 && minor == 4'd0) v = VER_1_0;
            if (maj == 4'd1 && minor == 4'd1) v = VER_1_1;
            if (maj == 4'd2 && minor == 4'd0) v = VER_2_0;
            ph = PH_LINE_CR;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_LINE_CR: if (c == CHR_CR) ph = PH_LINE_LF; else st = ST_REJECT;
        PH_LINE_LF: if (c == CHR_LF) ph = PH_NAME_START; else st = ST_REJECT;
        PH_NAME_START, PH_LWS: begin
          if (phase == PH_LWS && is_blank(c)) begin
            ph = PH_VALUE;
          end else if (c == CHR_CR) begin
            ph = PH_END;
          end else if (is_tchar(c)) begin
            k = FK_HNAME;
            hs = 1'b1;
            ph = PH_NAME;
          end else begin
            st = ST_REJECT;
          end
        end
        PH_NAME: begin
          if (is_tchar(c)) k = FK_HNAME;
          else if (c == CHR_COLON) ph = PH_VALUE;
          else st = ST_REJECT;
        end
        PH_VALUE: begin
          if (is_blank(c)) st = ST_PROGRESS;
          else if (c == CHR_CR) ph = PH_HDR_LF;
          else if (!is_ctl(c)) k = FK_HVALUE;
          else st = ST_REJECT;
        end
        PH_HDR_LF: if (c == CHR_LF) ph = PH_LWS; else st = ST_REJECT;
        PH_END: if (c == CHR_LF) st = ST_ACCEPT; else st = ST_REJECT;
        default: st = ST_REJECT;
      endcase
      if (st == ST_REJECT) begin
        k = FK_NONE;
        hs = 1'b0;
      end else begin
        phase = ph;
        uri_ph = up;
        meth = m;
        major = maj;
        ver = v;
      end
      w.status = st;
      w.meth = meth;
      w.ver = ver;
      w.kind = k;
      w.fbyte = (k != FK_NONE) ? c : 8'h00;
      w.hstart = hs;
      pending_words = {pending_words, w};
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
    endtask

    function int unsigned pending();
      return pending_words.size();
    endfunction

    task check_word(logic [1:0] st, logic [3:0] m, logic [2:0] v, logic [3:0] k,
                    logic [7:0] fb, logic hs);
      parse_word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("word with nothing pending: status %0d kind %0d byte %h",
                         st, k, fb));
        return;
      end
      w = pending_words.pop_front();
      words_seen++;
      if (st !== w.status || m !== w.meth || v !== w.ver || k !== w.kind ||
          fb !== w.fbyte || hs !== w.hstart) begin
        report($sformatf({"word %0d: got st %0d meth %0d ver %0d kind %0d byte %h hdr %0b,",
                          " want st %0d meth %0d ver %0d kind %0d byte %h hdr %0b"},
                         words_seen, st, m, v, k, fb, hs,
                         w.status, w.meth, w.ver, w.kind, w.fbyte, w.hstart));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       restart_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] parse_status_o;
  logic [3:0] method_code_o;
  logic [2:0] version_code_o;
  logic [3:0] field_kind_o;
  logic [7:0] field_byte_o;
  logic       header_start_o;

  parse_tracker tracker;
  logic [7:0]   req_bytes[$];
  string        token_chars = {"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
                               "0123456789!#$%&'*+-.^_|~"};
  int unsigned  items_sent = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;

  http_request_line_header_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .parse_status_o (parse_status_o),
    .method_code_o  (method_code_o),
    .version_code_o (version_code_o),
    .field_kind_o   (field_kind_o),
    .field_byte_o   (field_byte_o),
    .header_start_o (header_start_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Both handshakes are sampled here, before any of this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_word(parse_status_o, method_code_o, version_code_o, field_kind_o,
                           field_byte_o, header_start_o);
      end
      if (in_valid_i && !in_stall_o) tracker.parse_byte(data_byte_i, restart_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left = stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic rs);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    restart_i <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    calm = (items_sent >= CALM_AFTER);
  endtask

  task automatic send_queue(input logic first_restart, input int unsigned cut, input bit noisy);
    for (int unsigned i = 0; i < cut; i++) begin
      if (noisy && $urandom_range(0, 29) == 0) begin
        push_byte(8'($urandom_range(255, 0)), $urandom_range(0, 7) == 0);
      end
      push_byte(req_bytes[i], (i == 0) ? first_restart : 1'b0);
    end
  endtask

  function automatic void add_byte(logic [7:0] b);
    req_bytes = {req_bytes, b};
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CHR_CR);
    add_byte(CHR_LF);
  endfunction

  function automatic void add_token(int unsigned n);
    repeat (n) add_byte(token_chars[$urandom_range(token_chars.len() - 1, 0)]);
  endfunction

  function automatic void add_alpha(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(51, 0);
      add_byte((r < 26) ? 8'(CHR_UP_A + r) : 8'(CHR_LO_A + r - 26));
    end
  endfunction

  function automatic void add_digits(int unsigned n);
    repeat (n) add_byte(8'(CHR_ZERO + $urandom_range(9, 0)));
  endfunction

  function automatic void add_uri(int unsigned n);
    repeat (n) add_byte(8'($urandom_range(8'h7E, 8'h21)));
  endfunction

  function automatic void add_host(int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(8'h7E, 8'h21));
      if (b == CHR_SLASH || b == CHR_COLON) b = CHR_LO_A;
      add_byte(b);
    end
  endfunction

  function automatic void add_value(int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) begin
        b = CHR_TAB;
      end else begin
        b = 8'($urandom_range(255, 32));
        if (b == CHR_DEL) b = CHR_SPACE;
      end
      add_byte(b);
    end
  endfunction

  // One mostly well-formed request, sometimes cut short or left without a restart.
  task automatic send_request();
    int unsigned cut;
    req_bytes.delete();
    if ($urandom_range(0, 5) == 0) add_crlf();
    case ($urandom_range(0, 9))
      0: add_str("GET");
      1: add_str("HEAD");
      2: add_str("POST");
      3: add_str("PUT");
      4: add_str("PATCH");
      5: add_str("DELETE");
      6: add_str("CONNECT");
      7: add_str("OPTIONS");
      8: add_str("TRACE");
      default: begin
        add_str("P");
        add_token(2);
      end
    endcase
    if ($urandom_range(0, 3) == 0) add_token($urandom_range(0, 3));
    add_byte(CHR_SPACE);
    case ($urandom_range(0, 3))
      0, 1: begin
        add_byte(CHR_SLASH);
        add_uri($urandom_range(0, 10));
      end
      2: begin
        add_alpha($urandom_range(1, 5));
        add_str("://");
        add_host($urandom_range(1, 8));
        if ($urandom_range(0, 1) == 0) begin
          add_byte(CHR_COLON);
          add_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 2) != 0) begin
          add_byte(CHR_SLASH);
          add_uri($urandom_range(0, 8));
        end
      end
      default: add_uri($urandom_range(1, 8));
    endcase
    add_byte(CHR_SPACE);
    add_str("HTTP/");
    case ($urandom_range(0, 4))
      0: add_str("0.9");
      1: add_str("1.0");
      2: add_str("1.1");
      3: add_str("2.0");
      default: begin
        add_digits(1);
        add_byte(CHR_DOT);
        add_digits(1);
      end
    endcase
    add_crlf();
    repeat ($urandom_range(0, 4)) begin
      // A non-token byte where a header name should start must bounce.
      if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(255, 128)));
      add_token($urandom_range(1, 8));
      add_byte(CHR_COLON);
      if ($urandom_range(0, 1) == 0) add_byte(CHR_SPACE);
      add_value($urandom_range(0, 10));
      add_crlf();
      if ($urandom_range(0, 4) == 0) begin
        add_byte(($urandom_range(0, 1) == 0) ? CHR_SPACE : CHR_TAB);
        add_value($urandom_range(1, 6));
        add_crlf();
      end
    end
    add_crlf();
    repeat ($urandom_range(0, 2)) add_byte(CHR_LF);
    if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(255, 0)));
    cut = req_bytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(req_bytes.size(), 1);
    send_queue($urandom_range(0, 9) != 0, cut, 1'b1);
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rejects at request start, an empty line, rejects inside a P method that then resolves to PATCH,
    // then a short request that completes and completes again on a bare line feed.
    req_bytes.delete();
    add_byte(8'hFF);
    add_byte(8'h00);
    add_crlf();
    add_str("PZ A /?# HTTP/0.9");
    add_crlf();
    add_crlf();
    add_byte(CHR_LF);
    add_str("X");
    send_queue(1'b1, req_bytes.size(), 1'b0);

    while (items_sent < ITEM_COUNT) send_request();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.pending() != 0) tracker.report("words still pending at the end");
    if (tracker.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
